// ----- rtl/core/sshg_pkg.sv -----
// ----------------------------------------------------------------------------
// sshg_pkg
// Shared types, register indexes, constants and the saturation helper for the
// sinusoidal surface height and gradient evaluator.
// ----------------------------------------------------------------------------
package sshg_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_AMPLITUDE = 2'd0;
  localparam logic [1:0] REG_PERIOD    = 2'd1;
  localparam logic [1:0] REG_VERT_AXIS = 2'd2;

  localparam logic signed [31:0] AMP_RESET  = 32'sd65536;
  localparam logic [30:0]        PER_RESET  = 31'd65536;
  localparam logic [1:0]         VERT_RESET = 2'd2;

  // 2*pi in Q29
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
  localparam logic signed [31:0] Q16_ONE = 32'sd65536;

  // Lane pipeline: input, 32 remainder steps, fix-up, 32 phase steps,
  // 31 rotation stages, Q16 rounding, product, partial products, numerator,
  // 51 quotient steps, saturation.
  localparam int LANE_LAT  = 153;
  localparam int MERGE_LAT = 3;

  typedef struct packed {
    logic signed [31:0] amp;   // amplitude, Q16.16
    logic [30:0]        per;   // period with zero taken as one
    logic [31:0]        dsr;   // period * (axes - 1)
    logic [1:0]         vaxis; // vertical axis index
  } cfg_t;

  // Sign and magnitude to saturated 32-bit two's complement
  function automatic logic [31:0] sat32(input logic neg, input logic [52:0] mag);
    if (!neg) begin
      return (mag > 53'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
    end
    return (mag > 53'h80000000) ? 32'h80000000 : (~mag[31:0]) + 32'd1;
  endfunction

endpackage

// ----- rtl/core/sinusoidal_surface_height_gradient.sv -----
// ----------------------------------------------------------------------------
// sinusoidal_surface_height_gradient
// Height and gradient of a sinusoidal surface at a Q16.16 point, one lane
// per axis, fully pipelined.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_stall    in_coord_x, in_coord_y, in_coord_z
//   out      output     out_valid/out_stall  out_height, out_slope_x/y/z
//   cfg      input      cfg_wr_en            cfg_index, cfg_wdata
//
// One point per cycle; each point passes through 156 register stages, set by the
// remainder, phase and gradient long divisions and the CORDIC stages in each lane
// plus three merge stages.
// A stall on the result holds the whole pipeline and stalls the input.
// Reset clears the valid pipe and loads the register defaults.
// ----------------------------------------------------------------------------
module sinusoidal_surface_height_gradient #(
  parameter int NUM_AXES = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_coord_x,
  input  logic [31:0] in_coord_y,
  input  logic [31:0] in_coord_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_height,
  output logic [31:0] out_slope_x,
  output logic [31:0] out_slope_y,
  output logic [31:0] out_slope_z,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int LAT = sshg_pkg::LANE_LAT + sshg_pkg::MERGE_LAT;

  logic signed [31:0] amp_r;
  logic [30:0]        per_r;
  logic [1:0]         vaxis_r;
  logic [LAT-1:0]     vld_r;
  logic               en;
  sshg_pkg::cfg_t     cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r   <= sshg_pkg::AMP_RESET;
      per_r   <= sshg_pkg::PER_RESET;
      vaxis_r <= sshg_pkg::VERT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sshg_pkg::REG_AMPLITUDE: amp_r   <= cfg_wdata;
        sshg_pkg::REG_PERIOD:    per_r   <= cfg_wdata[30:0];
        sshg_pkg::REG_VERT_AXIS: vaxis_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.amp   = amp_r;
    cfg.per   = (per_r == '0) ? 31'd1 : per_r;
    cfg.dsr   = 32'(cfg.per) * 32'(NUM_AXES - 1);
    cfg.vaxis = vaxis_r;
  end

  // Advance unless a finished result is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[LAT-1];

  logic [31:0]        coords  [3];
  logic signed [17:0] sin_l   [NUM_AXES];
  logic [31:0]        slope_l [NUM_AXES];

  assign coords[0] = in_coord_x;
  assign coords[1] = in_coord_y;
  assign coords[2] = in_coord_z;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    sshg_lane u_lane (
      .clk     (clk),
      .en      (en),
      .cfg     (cfg),
      .coord   (coords[a]),
      .sin_o   (sin_l[a]),
      .slope_o (slope_l[a])
    );
  end

  sshg_merge #(
    .NUM_AXES (NUM_AXES)
  ) u_merge (
    .clk     (clk),
    .en      (en),
    .cfg     (cfg),
    .sin_i   (sin_l),
    .slope_i (slope_l),
    .height  (out_height),
    .slope_x (out_slope_x),
    .slope_y (out_slope_y),
    .slope_z (out_slope_z)
  );

`ifndef SYNTHESIS
  a_no_accept_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !(out_valid && out_stall))
    else $error("input beat taken while result held");

  a_valid_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(vld_r[LAT-2]))
    else $error("result valid without an item in flight");

  a_vertical_x: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && vaxis_r == 2'd0) |-> out_slope_x == 32'h00010000)
    else $error("vertical slope on axis 0 not one");
`endif

endmodule

// ----- rtl/core/sshg_cordic.sv -----
// ----------------------------------------------------------------------------
// sshg_cordic
// Pipelined rotation-mode CORDIC: a turn fraction in, sine and cosine out in
// signed Q1.16, clamped to plus or minus one.
// ----------------------------------------------------------------------------
module sshg_cordic (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        turn,
  output logic signed [17:0] sin_o,
  output logic signed [17:0] cos_o
);

  localparam int STEPS = 30;
  localparam logic signed [32:0] GAIN = 33'sd652032874;

  localparam logic [31:0] ATAN [0:STEPS-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  function automatic logic signed [17:0] to_q16(input logic signed [33:0] v);
    logic signed [33:0] s;
    s = (v + 34'sd8192) >>> 14;
    if (s > 34'sd65536) begin
      return 18'sd65536;
    end else if (s < -34'sd65536) begin
      return -18'sd65536;
    end
    return 18'(s);
  endfunction

  logic signed [32:0] x_r [0:STEPS];
  logic signed [32:0] y_r [0:STEPS];
  logic signed [31:0] z_r [0:STEPS];
  logic [1:0]         q_r [0:STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= GAIN;
      y_r[0] <= '0;
      z_r[0] <= {2'b00, turn[29:0]};
      q_r[0] <= turn[31:30];
    end
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= q_r[k-1];
        if (z_r[k-1] >= 0) begin
          x_r[k] <= x_r[k-1] - (y_r[k-1] >>> (k-1));
          y_r[k] <= y_r[k-1] + (x_r[k-1] >>> (k-1));
          z_r[k] <= z_r[k-1] - $signed(ATAN[k-1]);
        end else begin
          x_r[k] <= x_r[k-1] + (y_r[k-1] >>> (k-1));
          y_r[k] <= y_r[k-1] - (x_r[k-1] >>> (k-1));
          z_r[k] <= z_r[k-1] + $signed(ATAN[k-1]);
        end
      end
    end
  end

  logic signed [33:0] xe, ye;
  logic signed [17:0] sin_nxt, cos_nxt;
  logic signed [17:0] sin_r, cos_r;

  assign xe = 34'(x_r[STEPS]);
  assign ye = 34'(y_r[STEPS]);

  // Fold the first-quadrant result back to the full turn
  always_comb begin
    unique case (q_r[STEPS])
      2'd0: begin sin_nxt = to_q16(ye);  cos_nxt = to_q16(xe);  end
      2'd1: begin sin_nxt = to_q16(xe);  cos_nxt = to_q16(-ye); end
      2'd2: begin sin_nxt = to_q16(-ye); cos_nxt = to_q16(-xe); end
      default: begin sin_nxt = to_q16(-xe); cos_nxt = to_q16(ye); end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

// ----- rtl/core/sshg_lane.sv -----
// ----------------------------------------------------------------------------
// sshg_lane
// One axis: floored remainder by the period, phase as a turn fraction, sine
// and cosine, and the gradient component by long division.
// ----------------------------------------------------------------------------
module sshg_lane (
  input  logic               clk,
  input  logic               en,
  input  sshg_pkg::cfg_t     cfg,
  input  logic signed [31:0] coord,
  output logic signed [17:0] sin_o,
  output logic [31:0]        slope_o
);

  localparam int MOD_STEPS = 32;
  localparam int TRN_STEPS = 32;
  localparam int DIV_STEPS = 51;
  localparam int SIN_DLY   = DIV_STEPS + 4;

  // Remainder of |coord| by the period, one bit a stage
  logic [30:0] mr_r [0:MOD_STEPS];
  logic [31:0] mn_r [0:MOD_STEPS];
  logic        mg_r [0:MOD_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      mr_r[0] <= '0;
      mn_r[0] <= coord[31] ? (~coord) + 32'd1 : coord;
      mg_r[0] <= coord[31];
    end
  end

  for (genvar k = 1; k <= MOD_STEPS; k++) begin : g_mod
    logic [31:0] t;
    logic        ge;
    assign t  = {mr_r[k-1], mn_r[k-1][31]};
    assign ge = t >= {1'b0, cfg.per};
    always_ff @(posedge clk) begin
      if (en) begin
        mr_r[k] <= ge ? 31'(t - {1'b0, cfg.per}) : t[30:0];
        mn_r[k] <= {mn_r[k-1][30:0], 1'b0};
        mg_r[k] <= mg_r[k-1];
      end
    end
  end

  // Phase: floor(r * 2^32 / period); stage 0 applies the floored sign fix
  logic [30:0] tr_r [0:TRN_STEPS];
  logic [31:0] tq_r [0:TRN_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      tr_r[0] <= (mg_r[MOD_STEPS] && (mr_r[MOD_STEPS] != '0)) ?
                 cfg.per - mr_r[MOD_STEPS] : mr_r[MOD_STEPS];
      tq_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= TRN_STEPS; k++) begin : g_trn
    logic [31:0] t;
    logic        ge;
    assign t  = {tr_r[k-1], 1'b0};
    assign ge = t >= {1'b0, cfg.per};
    always_ff @(posedge clk) begin
      if (en) begin
        tr_r[k] <= ge ? 31'(t - {1'b0, cfg.per}) : t[30:0];
        tq_r[k] <= {tq_r[k-1][30:0], ge};
      end
    end
  end

  logic signed [17:0] sin_c, cos_c;

  sshg_cordic u_cordic (
    .clk   (clk),
    .en    (en),
    .turn  (tq_r[TRN_STEPS]),
    .sin_o (sin_c),
    .cos_o (cos_c)
  );

  // amplitude * cosine
  logic signed [49:0] m_r;
  logic               pneg_r;
  logic [63:0]        p0_r;
  logic [47:0]        p1_r;
  logic [47:0]        mmag;

  assign mmag = m_r[49] ? 48'(-m_r) : 48'(m_r);

  always_ff @(posedge clk) begin
    if (en) begin
      m_r    <= 50'(cfg.amp) * 50'(cos_c);
      pneg_r <= m_r[49];
      p0_r   <= 64'(mmag[31:0]) * 64'(sshg_pkg::TWO_PI_Q29);
      p1_r   <= 48'(mmag[47:32]) * 48'(sshg_pkg::TWO_PI_Q29);
    end
  end

  // Numerator with half the divisor added, low 29 bits dropped with the 2^29
  logic [79:0] num;
  assign num = 80'(p0_r) + {p1_r, 32'b0} + (80'(cfg.dsr) << 28);

  logic [31:0] dr_r [0:DIV_STEPS];
  logic [50:0] dn_r [0:DIV_STEPS];
  logic [32:0] dq_r [0:DIV_STEPS];
  logic        dv_r [0:DIV_STEPS];
  logic        dg_r [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      dr_r[0] <= '0;
      dn_r[0] <= num[79:29];
      dq_r[0] <= '0;
      dv_r[0] <= 1'b0;
      dg_r[0] <= pneg_r;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [32:0] t;
    logic        ge;
    assign t  = {dr_r[k-1], dn_r[k-1][50]};
    assign ge = t >= {1'b0, cfg.dsr};
    always_ff @(posedge clk) begin
      if (en) begin
        dr_r[k] <= ge ? 32'(t - {1'b0, cfg.dsr}) : t[31:0];
        dn_r[k] <= {dn_r[k-1][49:0], 1'b0};
        dq_r[k] <= {dq_r[k-1][31:0], ge};
        // a bit shifted out of the top means the quotient is far out of range
        dv_r[k] <= dv_r[k-1] | dq_r[k-1][32];
        dg_r[k] <= dg_r[k-1];
      end
    end
  end

  logic [52:0] qmag;
  logic [31:0] slope_r;

  assign qmag = dv_r[DIV_STEPS] ? '1 : 53'(dq_r[DIV_STEPS]);

  always_ff @(posedge clk) begin
    if (en) begin
      slope_r <= sshg_pkg::sat32(dg_r[DIV_STEPS], qmag);
    end
  end

  // Hold the sine alongside the gradient path
  logic signed [17:0] sd_r [0:SIN_DLY-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= sin_c;
    end
  end

  for (genvar k = 1; k < SIN_DLY; k++) begin : g_sdly
    always_ff @(posedge clk) begin
      if (en) begin
        sd_r[k] <= sd_r[k-1];
      end
    end
  end

  assign sin_o   = sd_r[SIN_DLY-1];
  assign slope_o = slope_r;

endmodule

// ----- rtl/core/sshg_merge.sv -----
// ----------------------------------------------------------------------------
// sshg_merge
// Combines the lanes: sums the sines, each plus one, of the non-vertical axes
// into the height and places the vertical and missing gradient components.
// ----------------------------------------------------------------------------
module sshg_merge #(
  parameter int NUM_AXES = 3
) (
  input  logic               clk,
  input  logic               en,
  input  sshg_pkg::cfg_t     cfg,
  input  logic signed [17:0] sin_i   [NUM_AXES],
  input  logic [31:0]        slope_i [NUM_AXES],
  output logic [31:0]        height,
  output logic [31:0]        slope_x,
  output logic [31:0]        slope_y,
  output logic [31:0]        slope_z
);

  localparam int HSH = 16 + $clog2(NUM_AXES - 1);
  localparam logic [52:0] HALF = 53'd1 << (HSH - 1);

  logic [19:0]        sum_nxt, sum_r;
  logic [31:0]        slp_nxt [3];
  logic [31:0]        slp_r   [3];
  logic [31:0]        slp2_r  [3];
  logic signed [52:0] prod_r;
  logic [31:0]        height_r;
  logic [31:0]        sx_r, sy_r, sz_r;

  always_comb begin
    logic signed [20:0] t;
    sum_nxt = '0;
    t       = '0;
    for (int a = 0; a < 3; a++) begin
      slp_nxt[a] = '0;
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      if (cfg.vaxis == 2'(a)) begin
        slp_nxt[a] = sshg_pkg::Q16_ONE;
      end else begin
        slp_nxt[a] = slope_i[a];
        t          = 21'(sin_i[a]) + 21'sd65536;
        sum_nxt    = sum_nxt + 20'(t);
      end
    end
  end

  logic        hneg;
  logic [52:0] hmag;
  logic [52:0] hrnd;

  assign hneg = prod_r[52];
  assign hmag = hneg ? 53'(-prod_r) : 53'(prod_r);
  assign hrnd = (hmag + HALF) >> HSH;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r    <= sum_nxt;
      slp_r    <= slp_nxt;
      prod_r   <= 53'(cfg.amp) * $signed({33'b0, sum_r});
      slp2_r   <= slp_r;
      height_r <= sshg_pkg::sat32(hneg, hrnd);
      sx_r     <= slp2_r[0];
      sy_r     <= slp2_r[1];
      sz_r     <= slp2_r[2];
    end
  end

  assign height  = height_r;
  assign slope_x = sx_r;
  assign slope_y = sy_r;
  assign slope_z = sz_r;

endmodule
